// File: hdl/pgwalk_pkg.sv
// ----------------------------------------------------------------------------
// pgwalk_pkg
// Shared types and constants for the four-level page-table walker.
// ----------------------------------------------------------------------------
package pgwalk_pkg;

  localparam int unsigned TBASE_W  = 40;
  localparam int unsigned VADDR_W  = 48;
  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned PADDR_W  = 52;
  localparam int unsigned FRAME_W  = PADDR_W - 12;
  localparam int unsigned LOW_W    = 30;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned PS_BIT   = 7;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_RESP  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_FAULT,
    CMD_PAGE_4K,
    CMD_PAGE_2M,
    CMD_PAGE_1G
  } cmd_e;

  // frame holds address bits 51:12; low holds the table index or page offset
  typedef struct packed {
    cmd_e               code;
    logic [FRAME_W-1:0] frame;
    logic [LOW_W-1:0]   low;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [PADDR_W-1:0] mem_read_addr;
    logic [PADDR_W-1:0] phys_addr;
    logic               fault;
  } res_t;

  typedef struct packed {
    logic busy;
  } front_status_t;

endpackage

// File: hdl/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page walk: start items issue the top-level entry read, read
// responses issue the next read or finish with the physical address or fault.
// ----------------------------------------------------------------------------
// One input item is taken per cycle while full is low. The walk state lives
// in the front stage and is updated in the cycle an item is transferred, so
// back-to-back items see each other's effect. A result reaches the output
// ports through a registered command queue (CmdDepth) and result queue
// (ResDepth); full rises only when both queues back up behind pop.
// Starts while a walk is open and responses while idle produce no result.
module four_level_page_table_walker #(
  parameter int unsigned CmdDepth = pgwalk_pkg::CMD_DEPTH,
  parameter int unsigned ResDepth = pgwalk_pkg::RES_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            op_i,
  input  logic [pgwalk_pkg::TBASE_W-1:0]  table_base_i,
  input  logic [pgwalk_pkg::VADDR_W-1:0]  virt_addr_i,
  input  logic [pgwalk_pkg::ENTRY_W-1:0]  read_data_i,
  input  logic                            read_ok_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            kind_o,
  output logic [pgwalk_pkg::PADDR_W-1:0]  mem_read_addr_o,
  output logic [pgwalk_pkg::PADDR_W-1:0]  phys_addr_o,
  output logic                            fault_o
);

  logic                          accept;
  logic                          cmd_push;
  pgwalk_pkg::cmd_t              cmd_in;
  logic [$bits(pgwalk_pkg::cmd_t)-1:0] cmd_bits;
  logic                          cmd_empty;
  logic                          cmd_pop;
  pgwalk_pkg::res_t              res;
  pgwalk_pkg::front_status_t     front_status;

  assign accept = push && !full;

  pgwalk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .op_i         (op_i),
    .table_base_i (table_base_i),
    .virt_addr_i  (virt_addr_i),
    .read_data_i  (read_data_i),
    .read_ok_i    (read_ok_i),
    .cmd_valid_o  (cmd_push),
    .cmd_o        (cmd_in),
    .status_o     (front_status)
  );

  pgwalk_fifo #(
    .Width ($bits(pgwalk_pkg::cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_bits),
    .empty_o (cmd_empty)
  );

  pgwalk_back #(
    .ResDepth (ResDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pgwalk_pkg::cmd_t'(cmd_bits)),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign kind_o          = res.kind;
  assign mem_read_addr_o = res.mem_read_addr;
  assign phys_addr_o     = res.phys_addr;
  assign fault_o         = res.fault;

  a_cmd_only_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> accept)
    else $error("command queued without an input transfer");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == pgwalk_pkg::OP_START) && !front_status.busy)
      |-> cmd_push ##1 front_status.busy)
    else $error("start while idle did not open a walk");

  a_resp_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == pgwalk_pkg::OP_RESP) && !front_status.busy) |-> !cmd_push)
    else $error("response while idle produced a result");

  a_result_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (fault_o || (kind_o == pgwalk_pkg::KIND_READ)))
      |-> (phys_addr_o == '0))
    else $error("request or fault result carries a physical address");

endmodule

// File: hdl/pgwalk_fifo.sv
// ----------------------------------------------------------------------------
// pgwalk_fifo
// Small first-word-fall-through queue with simultaneous push and pop.
// ----------------------------------------------------------------------------
module pgwalk_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2   // 2 or more
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/pgwalk_front.sv
// ----------------------------------------------------------------------------
// pgwalk_front
// Walk state and item classification: decides per item whether it is
// dropped, faults, requests the next entry or finishes with a page size.
// ----------------------------------------------------------------------------
module pgwalk_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic                            op_i,
  input  logic [pgwalk_pkg::TBASE_W-1:0]  table_base_i,
  input  logic [pgwalk_pkg::VADDR_W-1:0]  virt_addr_i,
  input  logic [pgwalk_pkg::ENTRY_W-1:0]  read_data_i,
  input  logic                            read_ok_i,
  output logic                            cmd_valid_o,
  output pgwalk_pkg::cmd_t                cmd_o,
  output pgwalk_pkg::front_status_t       status_o
);

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  logic                           busy_q, busy_d;
  logic [1:0]                     level_q, level_d;
  logic [pgwalk_pkg::VADDR_W-1:0] vaddr_q, vaddr_d;
  logic [pgwalk_pkg::FRAME_W-1:0] entry_frame;
  logic                           entry_ps;

  assign entry_frame     = read_data_i[pgwalk_pkg::PADDR_W-1:12];
  assign entry_ps        = read_data_i[pgwalk_pkg::PS_BIT];
  assign status_o.busy   = busy_q;

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    vaddr_d     = vaddr_q;
    cmd_valid_o = 1'b0;
    cmd_o.code  = pgwalk_pkg::CMD_FAULT;
    cmd_o.frame = '0;
    cmd_o.low   = '0;
    if (valid_i) begin
      if (op_i == pgwalk_pkg::OP_START) begin
        if (!busy_q) begin
          busy_d      = 1'b1;
          level_d     = LVL_PML4;
          vaddr_d     = virt_addr_i;
          cmd_valid_o = 1'b1;
          cmd_o.code  = pgwalk_pkg::CMD_READ;
          cmd_o.frame = {12'b0, table_base_i[pgwalk_pkg::TBASE_W-1:12]};
          cmd_o.low   = {21'b0, virt_addr_i[47:39]};
        end
      end else if (busy_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.frame = entry_frame;
        if (!read_ok_i || (read_data_i == '0)) begin
          busy_d      = 1'b0;
          level_d     = LVL_PML4;
          cmd_o.code  = pgwalk_pkg::CMD_FAULT;
          cmd_o.frame = '0;
        end else begin
          case (level_q)
            LVL_PML4: begin
              level_d    = LVL_PDPT;
              cmd_o.code = pgwalk_pkg::CMD_READ;
              cmd_o.low  = {21'b0, vaddr_q[38:30]};
            end
            LVL_PDPT: begin
              if (entry_ps) begin
                busy_d     = 1'b0;
                level_d    = LVL_PML4;
                cmd_o.code = pgwalk_pkg::CMD_PAGE_1G;
                cmd_o.low  = vaddr_q[29:0];
              end else begin
                level_d    = LVL_PD;
                cmd_o.code = pgwalk_pkg::CMD_READ;
                cmd_o.low  = {21'b0, vaddr_q[29:21]};
              end
            end
            LVL_PD: begin
              if (entry_ps) begin
                busy_d     = 1'b0;
                level_d    = LVL_PML4;
                cmd_o.code = pgwalk_pkg::CMD_PAGE_2M;
                cmd_o.low  = vaddr_q[29:0];
              end else begin
                level_d    = LVL_PT;
                cmd_o.code = pgwalk_pkg::CMD_READ;
                cmd_o.low  = {21'b0, vaddr_q[20:12]};
              end
            end
            default: begin
              busy_d     = 1'b0;
              level_d    = LVL_PML4;
              cmd_o.code = pgwalk_pkg::CMD_PAGE_4K;
              cmd_o.low  = vaddr_q[29:0];
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= LVL_PML4;
      vaddr_q <= '0;
    end else begin
      busy_q  <= busy_d;
      level_q <= level_d;
      vaddr_q <= vaddr_d;
    end
  end

endmodule

// File: hdl/pgwalk_back.sv
// ----------------------------------------------------------------------------
// pgwalk_back
// Forms request and physical addresses from queued commands and holds the
// results in an output queue.
// ----------------------------------------------------------------------------
module pgwalk_back #(
  parameter int unsigned ResDepth = pgwalk_pkg::RES_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pgwalk_pkg::cmd_t  cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output pgwalk_pkg::res_t  res_o,
  output logic              empty_o,
  input  logic              pop_i
);

  pgwalk_pkg::res_t res;
  logic             res_full;
  logic [$bits(pgwalk_pkg::res_t)-1:0] res_bits;

  always_comb begin
    res.kind          = pgwalk_pkg::KIND_DONE;
    res.mem_read_addr = '0;
    res.phys_addr     = '0;
    res.fault         = 1'b0;
    case (cmd_i.code)
      pgwalk_pkg::CMD_READ: begin
        res.kind          = pgwalk_pkg::KIND_READ;
        res.mem_read_addr = {cmd_i.frame, cmd_i.low[pgwalk_pkg::IDX_W-1:0], 3'b000};
      end
      pgwalk_pkg::CMD_PAGE_4K: res.phys_addr = {cmd_i.frame, cmd_i.low[11:0]};
      pgwalk_pkg::CMD_PAGE_2M: res.phys_addr = {cmd_i.frame[39:9], cmd_i.low[20:0]};
      pgwalk_pkg::CMD_PAGE_1G: res.phys_addr = {cmd_i.frame[39:18], cmd_i.low[29:0]};
      default:                 res.fault     = 1'b1;
    endcase
  end

  assign cmd_pop_o = !cmd_empty_i && !res_full;
  assign res_o     = pgwalk_pkg::res_t'(res_bits);

  pgwalk_fifo #(
    .Width ($bits(pgwalk_pkg::res_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (!cmd_empty_i),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_bits),
    .empty_o (empty_o)
  );

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the four-level page-table walker against its own predictor.
// Directed walks cover 4K, 2M and 1G pages, faults, dropped items and the
// extremes of every field, then random walks run under random input bursts
// and output stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TBASE_W   = pgwalk_pkg::TBASE_W;
  localparam int unsigned VADDR_W   = pgwalk_pkg::VADDR_W;
  localparam int unsigned ENTRY_W   = pgwalk_pkg::ENTRY_W;
  localparam int unsigned PADDR_W   = pgwalk_pkg::PADDR_W;
  localparam int unsigned PS_BIT    = pgwalk_pkg::PS_BIT;
  localparam logic        OP_START  = pgwalk_pkg::OP_START;
  localparam logic        OP_RESP   = pgwalk_pkg::OP_RESP;
  localparam logic        KIND_READ = pgwalk_pkg::KIND_READ;
  localparam logic        KIND_DONE = pgwalk_pkg::KIND_DONE;

  typedef pgwalk_pkg::res_t res_t;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef enum logic [1:0] {LVL_PML4, LVL_PDPT, LVL_PD, LVL_PT} walk_lvl_e;

  typedef struct packed {
    logic               op;
    logic [TBASE_W-1:0] tbase;
    logic [VADDR_W-1:0] vaddr;
    logic [ENTRY_W-1:0] entry;
    logic               ok;
  } walk_item_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               push          = 1'b0;
  logic               op_i          = OP_START;
  logic [TBASE_W-1:0] table_base_i  = '0;
  logic [VADDR_W-1:0] virt_addr_i   = '0;
  logic [ENTRY_W-1:0] read_data_i   = '0;
  logic               read_ok_i     = 1'b0;
  logic               pop           = 1'b0;
  logic               full;
  logic               empty;
  logic               kind_o;
  logic [PADDR_W-1:0] mem_read_addr_o;
  logic [PADDR_W-1:0] phys_addr_o;
  logic               fault_o;

  four_level_page_table_walker u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .table_base_i    (table_base_i),
    .virt_addr_i     (virt_addr_i),
    .read_data_i     (read_data_i),
    .read_ok_i       (read_ok_i),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .mem_read_addr_o (mem_read_addr_o),
    .phys_addr_o     (phys_addr_o),
    .fault_o         (fault_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // walk state of the predictor
  logic               walk_open  = 1'b0;
  walk_lvl_e          walk_lvl   = LVL_PML4;
  logic [VADDR_W-1:0] vaddr_held = '0;

  res_t        due_walk_res[$];
  res_t        due;
  res_t        got;
  int unsigned n_errors      = 0;
  int unsigned n_items       = 0;
  int unsigned n_dropped     = 0;
  int unsigned n_reads       = 0;
  int unsigned n_done        = 0;
  int unsigned n_faults      = 0;
  int unsigned n_full_cycles = 0;
  int unsigned n_walk_items  = 0;
  int unsigned stall_cycles  = 0;

  // sender bursts
  bit          sender_gaps = 1'b1;
  int unsigned burst_left  = 0;

  // receiver stall pattern and long hold-off
  logic [15:0] pop_pattern = 16'hFFFF;
  int unsigned rcv_cycle   = 0;
  int unsigned hold_left   = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_taken = 0;

  function automatic bit walk_step(input walk_item_t it, output res_t r);
    r = '0;
    if (it.op == OP_START) begin
      if (walk_open) return 1'b0;
      walk_open  = 1'b1;
      walk_lvl   = LVL_PML4;
      vaddr_held = it.vaddr;
      r.kind = KIND_READ;
      r.mem_read_addr = {12'h000, it.tbase[39:12], it.vaddr[47:39], 3'b000};
      return 1'b1;
    end
    if (!walk_open) return 1'b0;
    r.kind = KIND_DONE;
    if (!it.ok || it.entry == '0) begin
      r.fault = 1'b1;
    end else begin
      case (walk_lvl)
        LVL_PML4: begin
          walk_lvl = LVL_PDPT;
          r.kind = KIND_READ;
          r.mem_read_addr = {it.entry[51:12], vaddr_held[38:30], 3'b000};
        end
        LVL_PDPT: begin
          if (it.entry[PS_BIT]) begin
            r.phys_addr = {it.entry[51:30], vaddr_held[29:0]};
          end else begin
            walk_lvl = LVL_PD;
            r.kind = KIND_READ;
            r.mem_read_addr = {it.entry[51:12], vaddr_held[29:21], 3'b000};
          end
        end
        LVL_PD: begin
          if (it.entry[PS_BIT]) begin
            r.phys_addr = {it.entry[51:21], vaddr_held[20:0]};
          end else begin
            walk_lvl = LVL_PT;
            r.kind = KIND_READ;
            r.mem_read_addr = {it.entry[51:12], vaddr_held[20:12], 3'b000};
          end
        end
        default: begin
          r.phys_addr = {it.entry[51:12], vaddr_held[11:0]};
        end
      endcase
    end
    if (r.kind == KIND_DONE) begin
      walk_open = 1'b0;
      walk_lvl  = LVL_PML4;
    end
    return 1'b1;
  endfunction

  task automatic report_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
  endtask

  // results are checked before the transfer of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      got = {kind_o, mem_read_addr_o, phys_addr_o, fault_o};
      if (due_walk_res.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      end else begin
        due = due_walk_res.pop_front();
        if (got.kind != due.kind) report_field("kind", due.kind, got.kind);
        if (got.mem_read_addr != due.mem_read_addr)
          report_field("mem_read_addr", due.mem_read_addr, got.mem_read_addr);
        if (got.phys_addr != due.phys_addr)
          report_field("phys_addr", due.phys_addr, got.phys_addr);
        if (got.fault != due.fault) report_field("fault", due.fault, got.fault);
      end
    end
    if (rst_ni && push && !full) begin
      n_items++;
      if (walk_step({op_i, table_base_i, virt_addr_i, read_data_i, read_ok_i}, due)) begin
        due_walk_res.insert(due_walk_res.size(), due);
        if (due.kind == KIND_READ) n_reads++;
        else n_done++;
        if (due.fault) n_faults++;
      end else begin
        n_dropped++;
      end
    end
    if (rst_ni && push && full) n_full_cycles++;
  end

  always @(posedge clk_i) begin
    rcv_cycle <= rcv_cycle + 1;
    if (rcv_cycle % 64 == 63) begin
      case ($urandom_range(0, 3))
        0: pop_pattern <= 16'hFFFF;
        1: pop_pattern <= 16'($urandom);
        2: pop_pattern <= 16'($urandom | $urandom);
        default: pop_pattern <= 16'($urandom & $urandom) | 16'h0001;
      endcase
    end
    if (holds_asked != holds_taken) begin
      holds_taken <= holds_asked;
      hold_left   <= HOLD_CYCLES;
      pop         <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= pop_pattern[rcv_cycle % 16];
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic walk_item_t start_item(input logic [TBASE_W-1:0] tb,
                                            input logic [VADDR_W-1:0] va);
    walk_item_t it;
    it.op    = OP_START;
    it.tbase = tb;
    it.vaddr = va;
    it.entry = rand64();
    it.ok    = 1'($urandom);
    return it;
  endfunction

  function automatic walk_item_t resp_item(input logic [ENTRY_W-1:0] entry, input logic ok);
    walk_item_t it;
    it.op    = OP_RESP;
    it.tbase = TBASE_W'(rand64());
    it.vaddr = VADDR_W'(rand64());
    it.entry = entry;
    it.ok    = ok;
    return it;
  endfunction

  function automatic walk_item_t rand_start();
    return start_item(TBASE_W'(rand64()), VADDR_W'(rand64()));
  endfunction

  task automatic send_item(input walk_item_t it);
    if (sender_gaps && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    push         <= 1'b1;
    op_i         <= it.op;
    table_base_i <= it.tbase;
    virt_addr_i  <= it.vaddr;
    read_data_i  <= it.entry;
    read_ok_i    <= it.ok;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    do @(posedge clk_i); while (due_walk_res.size() != 0);
  endtask

  // one walk with random content; a few dropped starts, pauses and faults mixed in
  task automatic random_walk();
    walk_item_t  it;
    int unsigned lvl;
    int unsigned roll;
    bit          fin;
    if ($urandom_range(0, 19) == 0) send_item(resp_item(rand64(), 1'($urandom)));
    send_item(rand_start());
    n_walk_items++;
    lvl = 0;
    fin = 1'b0;
    while (!fin) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) send_item(rand_start());
      else if (roll < 7) wait_drain();
      it = resp_item(rand64(), 1'b1);
      if (roll >= 92) begin
        if (roll[0]) it.ok = 1'b0;
        else it.entry = '0;
        fin = 1'b1;
      end else begin
        if (it.entry == '0) it.entry[12] = 1'b1;
        if (lvl == 1 || lvl == 2) begin
          it.entry[PS_BIT] = ($urandom_range(0, 2) == 0);
          fin = it.entry[PS_BIT];
        end
        if (lvl == 3) fin = 1'b1;
      end
      send_item(it);
      n_walk_items++;
      lvl++;
    end
  endtask

  task automatic test_idle_response();
    send_item(resp_item('1, 1'b1));
    send_item(resp_item('0, 1'b0));
  endtask

  task automatic test_walk_extremes();
    // 1G page, all ones; bit 7 of the top entry is a plain pointer bit
    send_item(start_item('1, '1));
    send_item(resp_item('1, 1'b1));
    send_item(resp_item('1, 1'b1));
    // 2M page from zero base; entry with only bits above 51 set is present
    send_item(start_item('0, '0));
    send_item(resp_item(64'hFFF0_0000_0000_0000, 1'b1));
    send_item(resp_item(64'h0000_0000_0000_1000, 1'b1));
    send_item(resp_item(64'h0000_0000_0020_0080, 1'b1));
    // 4K page; bit 7 in the last entry is ignored
    send_item(start_item(40'hA5_A5A5_A5A5, 48'h5A5A_5A5A_5A5A));
    send_item(resp_item(64'h000F_FFFF_FFFF_F000, 1'b1));
    send_item(resp_item(64'h8000_0000_0000_0F7F, 1'b1));
    send_item(resp_item(64'h0000_0123_4567_8000, 1'b1));
    send_item(resp_item('1, 1'b1));
  endtask

  task automatic test_faults();
    send_item(rand_start());
    send_item(resp_item(rand64() | 64'h1, 1'b0));
    send_item(rand_start());
    send_item(resp_item(64'h0000_0000_0000_1000, 1'b1));
    send_item(resp_item(64'h0000_0000_0000_2000, 1'b1));
    send_item(resp_item('0, 1'b1));
  endtask

  task automatic test_busy_start();
    send_item(start_item(40'h12_3456_7000, 48'h0000_0000_0000));
    send_item(start_item(40'hFF_FFFF_F000, 48'hFFFF_FFFF_FFFF));
    send_item(resp_item(64'h0000_000A_BCDE_F000, 1'b1));
    send_item(resp_item('0, 1'b1));
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    holds_asked <= holds_asked + 1;
    repeat (8) random_walk();
    wait_drain();
    sender_gaps = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_item(rand_start());
    wait_drain();
    send_item(resp_item(64'h0000_0000_0004_0000, 1'b1));
    wait_drain();
    send_item(resp_item(64'h0000_0000_0008_0000, 1'b1));
    wait_drain();
    send_item(resp_item(64'h0000_0000_0060_0080, 1'b1));
  endtask

  task automatic test_random_walks();
    int unsigned target;
    target = n_walk_items + RANDOM_ITEMS;
    while (n_walk_items < target) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      random_walk();
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_response();
    test_walk_extremes();
    test_faults();
    test_busy_start();
    test_backpressure();
    test_drain_pause();
    test_random_walks();
    push <= 1'b0;
    do @(posedge clk_i); while (due_walk_res.size() != 0);
    repeat (16) @(posedge clk_i);
    $display("walker: %0d items (%0d dropped), %0d entry reads, %0d walks ended, %0d faults",
             n_items, n_dropped, n_reads, n_done, n_faults);
    $display("walker: input held off by full for %0d cycles, %0d long output hold-offs",
             n_full_cycles, holds_taken);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pgwalk_pkg.sv
hdl/pgwalk_fifo.sv
hdl/pgwalk_front.sv
hdl/pgwalk_back.sv
hdl/four_level_page_table_walker.sv
verif/testbench.sv
